// File: rtl/core/first_fit_block_allocator_defines.svh
// -----------------------------------------------------------------------------
// First-fit block allocator: assertion macros
// Concurrent checks used by the allocator; empty when synthesised.
// -----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define FFBA_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset
`define FFBA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("allocator check failed");

`else

`define FFBA_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// File: rtl/core/ffba_pkg.sv
// -----------------------------------------------------------------------------
// First-fit block allocator package
// Shared constants, codes and the control state type.
// -----------------------------------------------------------------------------
package ffba_pkg;

    localparam int HEAP_GRANULES_DEF = 1024;
    localparam int GRANULE_BYTES     = 32;
    localparam int HEADER_BYTES      = 16;
    localparam int GRAN_SHIFT        = $clog2(GRANULE_BYTES);

    localparam int ADDR_W   = 32;
    localparam int REQ_W    = 15;
    localparam int LIMIT_W  = 11;
    localparam int NEED_W   = REQ_W + 1;
    localparam int GRAN_W   = NEED_W - GRAN_SHIFT;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_GROW,
        FSM_DONE
    } fsm_t;

endpackage

// File: rtl/core/first_fit_block_allocator.sv
// -----------------------------------------------------------------------------
// First-fit block allocator
// Heap of fixed granules with block headers kept in one synchronous memory.
// -----------------------------------------------------------------------------
// One item is handled at a time. An allocate walks the block headers from the
// start of the heap, one header per cycle through the single read port of the
// header memory, until it finds a free block that fits; if none fits, or the
// heap is empty, it grows the heap top. A free walks the headers up to the
// addressed block, or is rejected at once when the address is misaligned or
// beyond the heap top. The next item is accepted as soon as the result has
// moved into the output register.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [ADDR_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [ADDR_W-1:0]   block_address,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ADDR_W-1:0]   payload_address,
    output logic [STATUS_W-1:0] status
);

    localparam int IDX_W = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;
    localparam int TOP_W = $clog2(HEAP_GRANULES + 1);
    localparam int G_W   = TOP_W + 1;
    localparam int SUM_W = ((TOP_W > LIMIT_W) ? TOP_W : LIMIT_W) + 1;

    typedef struct packed {
        logic             busy;
        logic [TOP_W-1:0] size;
    } header_t;

    header_t mem [HEAP_GRANULES];

    fsm_t                state_reg, state_next;
    logic [ADDR_W-1:0]   heap_base_reg;
    logic [LIMIT_W-1:0]  heap_limit_reg;
    logic [TOP_W-1:0]    heap_top_reg, heap_top_next;
    logic [TOP_W-1:0]    g_reg, g_next;
    logic [TOP_W-1:0]    target_reg, target_next;
    logic [GRAN_W-1:0]   gran_reg, gran_next;
    logic                cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    header_t             rd_data_reg;
    logic                mem_re, mem_we;
    logic [IDX_W-1:0]    rd_addr, wr_addr;
    header_t             wr_data;

    logic                in_accept;
    logic                slot_free;
    logic [NEED_W-1:0]   need_sum;
    logic [ADDR_W-1:0]   free_off;
    logic [ADDR_W-1:0]   free_target;
    logic                free_bad;
    logic [G_W-1:0]      g_sum;
    logic [SUM_W-1:0]    grow_sum;
    logic [SUM_W-1:0]    eff_limit;

    function automatic logic [ADDR_W-1:0] payload_of(
        input logic [ADDR_W-1:0] base,
        input logic [TOP_W-1:0]  g
    );
        payload_of = base + (ADDR_W'(g) << GRAN_SHIFT) + ADDR_W'(HEADER_BYTES);
    endfunction

    assign in_stall  = (state_reg != FSM_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign payload_address = out_addr_reg;
    assign status          = out_status_reg;

    // Granules needed, rounded up
    assign need_sum = NEED_W'(request_bytes) + NEED_W'(HEADER_BYTES + GRANULE_BYTES - 1);

    assign free_off    = block_address - heap_base_reg - ADDR_W'(HEADER_BYTES);
    assign free_target = free_off >> GRAN_SHIFT;
    assign free_bad    = (free_off[GRAN_SHIFT-1:0] != '0)
                      || (free_target >= ADDR_W'(heap_top_reg));

    assign g_sum     = G_W'(g_reg) + G_W'(rd_data_reg.size);
    assign grow_sum  = SUM_W'(heap_top_reg) + SUM_W'(gran_reg);
    assign eff_limit = (SUM_W'(heap_limit_reg) > SUM_W'(HEAP_GRANULES))
                     ? SUM_W'(HEAP_GRANULES) : SUM_W'(heap_limit_reg);

    always_comb
    begin
        state_next      = state_reg;
        heap_top_next   = heap_top_reg;
        g_next          = g_reg;
        target_next     = target_reg;
        gran_next       = gran_reg;
        cmd_next        = cmd_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        mem_re          = 1'b0;
        rd_addr         = '0;
        mem_we          = 1'b0;
        wr_addr         = g_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next      = command;
                    gran_next     = need_sum[NEED_W-1:GRAN_SHIFT];
                    target_next   = free_target[TOP_W-1:0];
                    g_next        = '0;
                    res_addr_next = '0;
                    if (command == CMD_FREE && free_bad)
                    begin
                        res_status_next = ST_BAD_FREE;
                        state_next      = FSM_DONE;
                    end
                    else if (command == CMD_ALLOC && heap_top_reg == '0)
                    begin
                        state_next = FSM_GROW;
                    end
                    else
                    begin
                        // Fetch the first header
                        mem_re     = 1'b1;
                        state_next = FSM_WALK;
                    end
                end
            end

            FSM_WALK:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (rd_data_reg.size == '0)
                    begin
                        state_next = FSM_GROW;
                    end
                    else if (!rd_data_reg.busy
                             && SUM_W'(rd_data_reg.size) >= SUM_W'(gran_reg))
                    begin
                        mem_we          = 1'b1;
                        wr_data.busy    = 1'b1;
                        res_addr_next   = payload_of(heap_base_reg, g_reg);
                        res_status_next = ST_OK;
                        state_next      = FSM_DONE;
                    end
                    else if (g_sum >= G_W'(heap_top_reg))
                    begin
                        state_next = FSM_GROW;
                    end
                    else
                    begin
                        g_next     = g_sum[TOP_W-1:0];
                        mem_re     = 1'b1;
                        rd_addr    = g_sum[IDX_W-1:0];
                    end
                end
                else
                begin
                    if (g_reg == target_reg)
                    begin
                        if (rd_data_reg.busy)
                        begin
                            mem_we          = 1'b1;
                            wr_data.busy    = 1'b0;
                            res_status_next = ST_OK;
                        end
                        else
                        begin
                            res_status_next = ST_BAD_FREE;
                        end
                        state_next = FSM_DONE;
                    end
                    else if (rd_data_reg.size == '0 || g_reg > target_reg
                             || g_sum >= G_W'(heap_top_reg))
                    begin
                        res_status_next = ST_BAD_FREE;
                        state_next      = FSM_DONE;
                    end
                    else
                    begin
                        g_next  = g_sum[TOP_W-1:0];
                        mem_re  = 1'b1;
                        rd_addr = g_sum[IDX_W-1:0];
                    end
                end
            end

            FSM_GROW:
            begin
                if (grow_sum > eff_limit)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_NO_SPACE;
                end
                else
                begin
                    // Fits under the limit, so the size field holds it
                    mem_we          = 1'b1;
                    wr_addr         = heap_top_reg[IDX_W-1:0];
                    wr_data.busy    = 1'b1;
                    wr_data.size    = TOP_W'(gran_reg);
                    res_addr_next   = payload_of(heap_base_reg, heap_top_reg);
                    res_status_next = ST_OK;
                    heap_top_next   = grow_sum[TOP_W-1:0];
                end
                state_next = FSM_DONE;
            end

            FSM_DONE:
            begin
                // Hold until the output register can take the item
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            heap_top_reg   <= '0;
            out_valid_reg  <= 1'b0;
            heap_base_reg  <= '0;
            heap_limit_reg <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            heap_top_reg  <= heap_top_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                    CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:        heap_base_reg  <= heap_base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg          <= g_next;
        target_reg     <= target_next;
        gran_reg       <= gran_next;
        cmd_reg        <= cmd_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // Header memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `FFBA_ASSERT_NOW(a_top_bound, clk, rst_n, 1'b1, heap_top_reg <= TOP_W'(HEAP_GRANULES))
    `FFBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_accept, state_reg != FSM_IDLE)
    `FFBA_ASSERT_NOW(a_no_space_zero, clk, rst_n, out_valid_reg && out_status_reg == ST_NO_SPACE, out_addr_reg == '0)
    `FFBA_ASSERT_NEXT(a_top_grows_only, clk, rst_n, state_reg != FSM_GROW, $stable(heap_top_reg))

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// First-fit block allocator testbench
// Sends allocate and free items through the valid/stall handshake and keeps a
// shadow heap. Each returned item is checked against the shadow heap, over
// several heap bases and limits and under random gaps and stalls.
// -----------------------------------------------------------------------------
module tb_top;
    import ffba_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    typedef struct {
        command_t          op;
        logic [REQ_W-1:0]  bytes;
        logic [ADDR_W-1:0] addr;
    } heap_cmd_t;

    typedef struct {
        logic [ADDR_W-1:0] payload;
        status_t           st;
    } heap_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic                cfg_index = 1'b0;
    logic [ADDR_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = 1'b0;
    logic [REQ_W-1:0]    request_bytes = '0;
    logic [ADDR_W-1:0]   block_address = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [ADDR_W-1:0]   payload_address;
    logic [STATUS_W-1:0] status;

    // shadow heap
    logic [ADDR_W-1:0]  shadow_base = '0;
    logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;
    logic [LIMIT_W-1:0] shadow_top = '0;
    bit                 hdr_busy [HEAP_GRANULES_DEF];
    bit [LIMIT_W-1:0]   hdr_size [HEAP_GRANULES_DEF];
    int                 live_granules [$];

    heap_cmd_t   commands_to_send [$];
    heap_reply_t heap_replies_due [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    first_fit_block_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .request_bytes   (request_bytes),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_address (payload_address),
        .status          (status)
    );

    always #2 clk = ~clk;

    function automatic logic [ADDR_W-1:0] payload_at(input int g);
        return shadow_base + (32'(g) << GRAN_SHIFT) + 32'(HEADER_BYTES);
    endfunction

    function automatic heap_reply_t apply_heap_command(input heap_cmd_t c);
        heap_reply_t       r;
        int                gran;
        int                g;
        int                lim;
        int                target;
        int                slot;
        bit                walking;
        bit                granted;
        logic [ADDR_W-1:0] off;
        r.payload = '0;
        r.st = ST_OK;
        g = 0;
        slot = -1;
        walking = 1'b1;
        granted = 1'b0;
        if (c.op == CMD_ALLOC) begin
            gran = (int'(c.bytes) + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
            while (walking && g < int'(shadow_top)) begin
                if (hdr_size[g] == '0) begin
                    walking = 1'b0;
                end
                else if (!hdr_busy[g] && int'(hdr_size[g]) >= gran) begin
                    hdr_busy[g] = 1'b1;
                    r.payload = payload_at(g);
                    live_granules.push_back(g);
                    walking = 1'b0;
                    granted = 1'b1;
                end
                else begin
                    g += int'(hdr_size[g]);
                end
            end
            if (!granted) begin
                lim = (int'(shadow_limit) > HEAP_GRANULES_DEF) ? HEAP_GRANULES_DEF
                                                              : int'(shadow_limit);
                if (int'(shadow_top) + gran > lim) begin
                    r.st = ST_NO_SPACE;
                end
                else begin
                    hdr_busy[shadow_top] = 1'b1;
                    hdr_size[shadow_top] = LIMIT_W'(gran);
                    r.payload = payload_at(int'(shadow_top));
                    live_granules.push_back(int'(shadow_top));
                    shadow_top = shadow_top + LIMIT_W'(gran);
                end
            end
        end
        else begin
            r.st = ST_BAD_FREE;
            off = c.addr - shadow_base - 32'(HEADER_BYTES);
            if (off[GRAN_SHIFT-1:0] == '0 && (off >> GRAN_SHIFT) < 32'(shadow_top)) begin
                target = int'(off >> GRAN_SHIFT);
                while (walking && g < int'(shadow_top)) begin
                    if (g == target) begin
                        if (hdr_busy[g]) begin
                            hdr_busy[g] = 1'b0;
                            r.st = ST_OK;
                            foreach (live_granules[i])
                                if (live_granules[i] == g)
                                    slot = i;
                            if (slot >= 0)
                                live_granules.delete(slot);
                        end
                        walking = 1'b0;
                    end
                    else if (hdr_size[g] == '0 || g > target) begin
                        walking = 1'b0;
                    end
                    else begin
                        g += int'(hdr_size[g]);
                    end
                end
            end
        end
        return r;
    endfunction

    // Driver: offer the next item once the current one has gone
    always @(posedge clk)
    begin : driver
        heap_cmd_t next_cmd;
        if (rst_n && (!in_valid || !in_stall)) begin
            if (commands_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_cmd = commands_to_send.pop_front();
                in_valid <= 1'b1;
                command <= next_cmd.op;
                request_bytes <= next_cmd.bytes;
                block_address <= next_cmd.addr;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted item, check each returned item
    always @(posedge clk)
    begin : monitor
        heap_cmd_t   taken;
        heap_reply_t due;
        if (rst_n) begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (in_valid && !in_stall) begin
                taken.op = command_t'(command);
                taken.bytes = request_bytes;
                taken.addr = block_address;
                heap_replies_due.push_back(apply_heap_command(taken));
            end
            if (out_valid && !out_stall) begin
                if (heap_replies_due.size() == 0) begin
                    $display("%0t: unexpected item, payload_address %h status %0d",
                             $time, payload_address, status);
                    mismatches++;
                end
                else begin
                    due = heap_replies_due.pop_front();
                    if (payload_address !== due.payload) begin
                        $display("%0t: payload_address expected %h, got %h",
                                 $time, due.payload, payload_address);
                        mismatches++;
                    end
                    if (status !== due.st) begin
                        $display("%0t: status expected %0d, got %0d", $time, due.st, status);
                        mismatches++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("** first_fit_block_allocator: FAILED **");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [ADDR_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_HEAP_BASE)
            shadow_base = value;
        else
            shadow_limit = value[LIMIT_W-1:0];
        @(negedge clk);
    endtask

    task automatic drain();
        while (commands_to_send.size() != 0 || in_valid || heap_replies_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic send(input command_t op, input int bytes, input logic [ADDR_W-1:0] addr);
        heap_cmd_t c;
        c.op = op;
        c.bytes = REQ_W'(bytes);
        c.addr = addr;
        commands_to_send.push_back(c);
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit,
                             input int send_pct, input int stall_chance, input int count);
        heap_cmd_t c;
        int        pick;
        int        g;
        drain();
        write_reg(CFG_HEAP_BASE, base);
        write_reg(CFG_HEAP_LIMIT, limit);
        send_idle_pct = send_pct;
        stall_pct = stall_chance;
        for (int n = 0; n < count; n++) begin
            // hold off now and then until every item has come back
            if ($urandom_range(59) == 0)
                drain();
            while (commands_to_send.size() >= 2)
                @(negedge clk);
            pick = $urandom_range(99);
            c.bytes = REQ_W'($urandom);
            c.addr = $urandom;
            if ($urandom_range(99) < 55) begin
                c.op = CMD_ALLOC;
                if (pick < 60)
                    c.bytes = REQ_W'($urandom_range(200));
                else if (pick < 90)
                    c.bytes = REQ_W'($urandom_range(2000, 201));
                else if (pick < 98)
                    c.bytes = REQ_W'($urandom_range(8000, 2001));
                else
                    c.bytes = REQ_W'($urandom_range(32752, 8001));
            end
            else begin
                c.op = CMD_FREE;
                if (pick < 70 && live_granules.size() > 0) begin
                    g = live_granules[$urandom_range(live_granules.size() - 1)];
                    c.addr = payload_at(g);
                end
                else if (pick < 80) begin
                    c.addr = $urandom;
                end
                else if (pick < 90) begin
                    // block starts, mid-block granules and beyond the top
                    c.addr = payload_at($urandom_range(int'(shadow_top) + 4));
                end
                else begin
                    c.addr = payload_at($urandom_range(int'(shadow_top)))
                             + 32'($urandom_range(GRANULE_BYTES - 1, 1));
                end
            end
            commands_to_send.push_back(c);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // nothing may grow: every allocate runs out of space
        write_reg(CFG_HEAP_BASE, 32'h0000_0000);
        write_reg(CFG_HEAP_LIMIT, 32'd0);
        send(CMD_ALLOC, 0, 32'hFFFF_FFFF);
        send(CMD_ALLOC, 32752, 32'h0);
        send(CMD_FREE, 32767, 32'h0000_0010);
        drain();

        // one granule: fill it, free it, free again, reuse, misaligned free
        write_reg(CFG_HEAP_LIMIT, 32'd1);
        send(CMD_ALLOC, 0, 32'h0);
        send(CMD_ALLOC, 16, 32'h0);
        send(CMD_FREE, 0, 32'h0000_0010);
        send(CMD_FREE, 0, 32'h0000_0010);
        send(CMD_ALLOC, 16, 32'h0);
        send(CMD_FREE, 0, 32'h0000_0011);
        send(CMD_FREE, 0, 32'hFFFF_FFFF);
        drain();

        // base near the top of the address space so payloads wrap;
        // limit above the store acts as the store size
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFC0);
        write_reg(CFG_HEAP_LIMIT, 32'd2047);
        send(CMD_ALLOC, 1, 32'h0);
        send(CMD_ALLOC, 48, 32'h0);
        send(CMD_FREE, 0, 32'h0000_0010);
        send(CMD_ALLOC, 17, 32'h0);
        send(CMD_FREE, 0, 32'h0000_0030);
        send(CMD_ALLOC, 32752, 32'h0);
        drain();

        // freeing is checked against the base as it now stands
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
        send(CMD_FREE, 0, 32'h0000_000F);
        send(CMD_FREE, 0, 32'h0000_000F);
        send(CMD_ALLOC, 0, 32'h0);
        drain();

        run_phase(32'h0000_0000, 32'd96, 0, 0, 300);
        run_phase($urandom, 32'd300, 75, 0, 300);
        run_phase(32'hFFFF_F000, 32'd700, 0, 75, 300);
        run_phase($urandom, 32'd1024, 16, 16, 300);
        run_phase(32'hFFFF_FFFF, 32'd2047, 0, 0, 300);
        run_phase($urandom, 32'd40, 75, 75, 300);

        drain();
        repeat (64) @(posedge clk);
        if (heap_replies_due.size() != 0) begin
            $display("%0t: %0d items never returned", $time, heap_replies_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** first_fit_block_allocator: PASSED **");
        else
            $display("** first_fit_block_allocator: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/first_fit_block_allocator.sv
sim/tb_top.sv
